FILE: sv/lqs_pkg.sv
// Package for the linear queue with search.
// Holds sizes, request/status codes, sequencer states and the payload structs.
// No dependencies.
package lqs_pkg;

  localparam int unsigned DEPTH  = 8;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_ENQ    = 2'd0,
    REQ_DEQ    = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_SEARCH = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_PEEK,
    S_SCAN
  } state_e;

  typedef struct packed {
    req_e                      req_type;
    logic signed [DATA_W-1:0]  data_in;
  } req_t;

  typedef struct packed {
    status_e                   status;
    logic signed [DATA_W-1:0]  data_out;
    logic [IDX_W-1:0]          slot_index;
    logic [CNT_W-1:0]          occupancy;
  } rsp_t;

endpackage

FILE: sv/linear_queue_with_search.sv
// Enqueue, or a request on an empty queue: result the cycle after the transfer; busy stays low.
// Dequeue and peek: one slot-memory read, then the S_DEQ or S_PEEK state strobes the result.
// Search: the result is strobed on the first held entry that matches, or as not found after the
// last held entry; the single comparator walks the slot memory one entry per cycle.
// Results are strobed for one cycle; the receiver cannot stall. Reset (async, active low)
// clears the pointers and sequencer; slot contents are undefined until written.
module linear_queue_with_search (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  lqs_pkg::req_t req_i,
  output logic          strobe_o,
  output lqs_pkg::rsp_t rsp_o
);

  logic [lqs_pkg::DATA_W-1:0] mem [lqs_pkg::DEPTH];

  lqs_pkg::state_e             state_q, state_d;
  logic [lqs_pkg::CNT_W-1:0]   head_q, head_d;
  logic [lqs_pkg::CNT_W-1:0]   tail_q, tail_d;
  logic [lqs_pkg::IDX_W-1:0]   scan_q, scan_d;
  logic [lqs_pkg::DATA_W-1:0]  key_q, key_d;
  logic [lqs_pkg::DATA_W-1:0]  rd_data_q;
  lqs_pkg::rsp_t               rsp_q, rsp_d;
  logic                        strobe_q, strobe_d;

  logic                        wr_en;
  logic [lqs_pkg::IDX_W-1:0]   rd_addr;
  logic                        empty;
  logic [lqs_pkg::CNT_W-1:0]   head_inc;
  logic [lqs_pkg::CNT_W-1:0]   scan_inc;

  assign empty    = (head_q == tail_q);
  assign head_inc = head_q + lqs_pkg::CNT_W'(1);
  assign scan_inc = {1'b0, scan_q} + lqs_pkg::CNT_W'(1);
  assign busy     = (state_q != lqs_pkg::S_IDLE);
  assign strobe_o = strobe_q;
  assign rsp_o    = rsp_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[tail_q[lqs_pkg::IDX_W-1:0]] <= key_d;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lqs_pkg::S_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    key_q  <= key_d;
    rsp_q  <= rsp_d;
  end

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    scan_d   = scan_q;
    key_d    = key_q;
    rsp_d    = rsp_q;
    strobe_d = 1'b0;
    wr_en    = 1'b0;
    rd_addr  = head_q[lqs_pkg::IDX_W-1:0];

    unique case (state_q)
      lqs_pkg::S_IDLE: begin
        if (start) begin
          key_d = req_i.data_in;
          rsp_d.status     = lqs_pkg::ST_OK;
          rsp_d.data_out   = '0;
          rsp_d.slot_index = '0;
          rsp_d.occupancy  = tail_q - head_q;
          unique case (req_i.req_type) inside
            lqs_pkg::REQ_ENQ: begin
              strobe_d = 1'b1;
              if (tail_q == lqs_pkg::CNT_W'(lqs_pkg::DEPTH)) begin
                rsp_d.status = lqs_pkg::ST_FULL;
              end else begin
                wr_en           = 1'b1;
                tail_d          = tail_q + lqs_pkg::CNT_W'(1);
                rsp_d.occupancy = tail_d - head_q;
              end
            end
            lqs_pkg::REQ_DEQ, lqs_pkg::REQ_PEEK, lqs_pkg::REQ_SEARCH: begin
              if (empty) begin
                strobe_d     = 1'b1;
                rsp_d.status = lqs_pkg::ST_EMPTY;
              end else if (req_i.req_type == lqs_pkg::REQ_DEQ) begin
                state_d = lqs_pkg::S_DEQ;
              end else if (req_i.req_type == lqs_pkg::REQ_PEEK) begin
                state_d = lqs_pkg::S_PEEK;
              end else begin
                scan_d  = head_q[lqs_pkg::IDX_W-1:0];
                state_d = lqs_pkg::S_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      lqs_pkg::S_DEQ: begin
        strobe_d       = 1'b1;
        state_d        = lqs_pkg::S_IDLE;
        rsp_d.data_out = rd_data_q;
        // last entry out: both pointers rewind
        if (head_inc >= tail_q) begin
          head_d = '0;
          tail_d = '0;
        end else begin
          head_d = head_inc;
        end
        rsp_d.occupancy = tail_d - head_d;
      end

      lqs_pkg::S_PEEK: begin
        strobe_d       = 1'b1;
        state_d        = lqs_pkg::S_IDLE;
        rsp_d.data_out = rd_data_q;
      end

      lqs_pkg::S_SCAN: begin
        // rd_data_q holds mem[scan_q]; prefetch the next slot
        rd_addr = scan_inc[lqs_pkg::IDX_W-1:0];
        if (rd_data_q == key_q) begin
          strobe_d         = 1'b1;
          state_d          = lqs_pkg::S_IDLE;
          rsp_d.status     = lqs_pkg::ST_OK;
          rsp_d.slot_index = scan_q;
        end else if (scan_inc == tail_q) begin
          strobe_d     = 1'b1;
          state_d      = lqs_pkg::S_IDLE;
          rsp_d.status = lqs_pkg::ST_NOTFOUND;
        end else begin
          scan_d = scan_inc[lqs_pkg::IDX_W-1:0];
        end
      end

      default: state_d = lqs_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: bench/linear_queue_with_search_tb.sv
// Self-checking bench for linear_queue_with_search: directed corner cases, then random traffic.
// Uses lqs_pkg for sizes, codes and the request/response structs; needs only the RTL.
module linear_queue_with_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lqs_pkg::*;

  localparam int unsigned N_RANDOM     = 1025;
  localparam int unsigned N_PHASES     = 4;
  localparam int unsigned STALL_LIMIT  = 200;
  localparam int unsigned DRAIN_CYCLES = DEPTH + 4;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_PROBE} mix_e;

  class lqs_scoreboard;
    logic [DATA_W-1:0] slot_mem [DEPTH];
    int unsigned head_q;
    int unsigned tail_q;
    rsp_t        pending_rsp [$];
    int unsigned n_errors;
    int unsigned n_checked;
    int unsigned req_seen [4];
    int unsigned status_seen [4];

    function new();
      head_q    = 0;
      tail_q    = 0;
      n_errors  = 0;
      n_checked = 0;
      foreach (req_seen[i]) req_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // Applies one request to the modeled queue and returns the response it owes.
    function rsp_t advance_queue(req_t r);
      rsp_t        e;
      int unsigned i;
      bit          found;
      e        = '0;
      e.status = ST_OK;
      found    = 1'b0;
      case (r.req_type)
        REQ_ENQ: begin
          // linear: full once the last slot is used; only the last dequeue frees slots, by rewinding
          if (tail_q >= DEPTH) begin
            e.status = ST_FULL;
          end else begin
            slot_mem[tail_q] = r.data_in;
            tail_q++;
          end
        end
        REQ_DEQ: begin
          if (head_q >= tail_q) begin
            e.status = ST_EMPTY;
          end else begin
            e.data_out = slot_mem[head_q];
            head_q++;
            if (head_q >= tail_q) begin
              head_q = 0;
              tail_q = 0;
            end
          end
        end
        REQ_PEEK: begin
          if (head_q >= tail_q) e.status = ST_EMPTY;
          else e.data_out = slot_mem[head_q];
        end
        default: begin
          if (head_q >= tail_q) begin
            e.status = ST_EMPTY;
          end else begin
            e.status = ST_NOTFOUND;
            for (i = head_q; i < tail_q; i++) begin
              if (!found && slot_mem[i] == r.data_in) begin
                found        = 1'b1;
                e.status     = ST_OK;
                e.slot_index = IDX_W'(i);
              end
            end
          end
        end
      endcase
      e.occupancy = CNT_W'(tail_q - head_q);
      return e;
    endfunction

    function void note_request(req_t r);
      req_seen[r.req_type]++;
      pending_rsp.push_back(advance_queue(r));
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp;
      if (pending_rsp.size() == 0) begin
        $error("response with no request outstanding: status %0d data_out %0h",
               got.status, got.data_out);
        n_errors++;
        return;
      end
      exp = pending_rsp.pop_front();
      n_checked++;
      status_seen[exp.status]++;
      if (got.status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, got.status);
        n_errors++;
      end
      if (got.data_out !== exp.data_out) begin
        $error("data_out: expected %0h, actual %0h", exp.data_out, got.data_out);
        n_errors++;
      end
      if (got.slot_index !== exp.slot_index) begin
        $error("slot_index: expected %0d, actual %0d", exp.slot_index, got.slot_index);
        n_errors++;
      end
      if (got.occupancy !== exp.occupancy) begin
        $error("occupancy: expected %0d, actual %0d", exp.occupancy, got.occupancy);
        n_errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_rsp.size();
    endfunction
  endclass

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        start    = 1'b0;
  req_t        req_i    = '0;
  logic        busy;
  logic        strobe_o;
  rsp_t        rsp_o;

  lqs_scoreboard     sb;
  int unsigned       n_accepted   = 0;
  int unsigned       idle_pct     = 0;
  int unsigned       quiet_cycles = 0;
  logic [DATA_W-1:0] value_pool [16];

  linear_queue_with_search DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .req_i    (req_i),
    .strobe_o (strobe_o),
    .rsp_o    (rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // response can never land in the same cycle as its own transfer, so order here is free
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (strobe_o) sb.check_response(rsp_o);
      if (start && !busy) begin
        sb.note_request(req_i);
        n_accepted <= n_accepted + 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (strobe_o || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("linear_queue_with_search_tb: FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Called and returns at a falling edge; holds start until the transfer happens.
  task automatic send(input req_e kind, input logic [DATA_W-1:0] value);
    int unsigned target;
    int unsigned gap;
    req_t        r;
    target = n_accepted + 1;
    gap    = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 4);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    r.req_type = kind;
    r.data_in  = value;
    start <= 1'b1;
    req_i <= r;
    do @(negedge clk_i); while (n_accepted < target);
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return $urandom;
      1: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      // small pool so searches hit entries that are actually held
      default: return value_pool[$urandom_range(15)];
    endcase
  endfunction

  function automatic req_e pick_kind(input mix_e mix);
    int unsigned roll;
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        if (roll < 65) return REQ_ENQ;
        if (roll < 75) return REQ_DEQ;
        if (roll < 85) return REQ_PEEK;
        return REQ_SEARCH;
      end
      MIX_DRAIN: begin
        if (roll < 15) return REQ_ENQ;
        if (roll < 65) return REQ_DEQ;
        if (roll < 80) return REQ_PEEK;
        return REQ_SEARCH;
      end
      default: begin
        if (roll < 30) return REQ_ENQ;
        if (roll < 45) return REQ_DEQ;
        if (roll < 60) return REQ_PEEK;
        return REQ_SEARCH;
      end
    endcase
  endfunction

  initial begin
    int   burst_left;
    mix_e mix;
    sb         = new();
    burst_left = 0;
    mix        = MIX_FILL;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty-queue requests
    send(REQ_DEQ, 32'h0000_0000);
    send(REQ_PEEK, 32'hFFFF_FFFF);
    send(REQ_SEARCH, 32'h0000_0000);
    // fill every slot and overflow once, with a duplicate so search must return the first match
    send(REQ_ENQ, 32'h8000_0000);
    send(REQ_ENQ, 32'h7FFF_FFFF);
    send(REQ_ENQ, 32'h0000_0000);
    send(REQ_ENQ, 32'hFFFF_FFFF);
    send(REQ_ENQ, 32'h5555_5555);
    send(REQ_ENQ, 32'hAAAA_AAAA);
    send(REQ_ENQ, 32'h7FFF_FFFF);
    send(REQ_ENQ, 32'h0000_0001);
    send(REQ_ENQ, 32'h0000_007B);
    send(REQ_SEARCH, 32'h7FFF_FFFF);
    send(REQ_SEARCH, 32'h0000_0001);
    send(REQ_SEARCH, 32'h0000_0002);
    send(REQ_PEEK, 32'h0000_0000);
    send(REQ_DEQ, 32'h0000_0000);
    send(REQ_DEQ, 32'h0000_0000);
    // first match now lies past the head; queue still full after dequeues
    send(REQ_SEARCH, 32'h7FFF_FFFF);
    send(REQ_ENQ, 32'h1234_5678);
    // drain the rest: pointers go back to zero on the last dequeue
    repeat (6) send(REQ_DEQ, 32'h0000_0000);
    send(REQ_ENQ, 32'h0000_002A);
    send(REQ_PEEK, 32'h0000_0000);

    for (int p = 0; p < N_PHASES; p++) begin
      idle_pct = (p == 1) ? 48 : (p == 3) ? 14 : 0;
      foreach (value_pool[i]) value_pool[i] = $urandom;
      for (int n = 0; n < N_RANDOM / N_PHASES; n++) begin
        if (burst_left == 0) begin
          mix        = mix_e'($urandom_range(2));
          burst_left = $urandom_range(2, 16);
        end
        burst_left--;
        send(pick_kind(mix), pick_value());
      end
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests: enqueue %0d, dequeue %0d, peek %0d, search %0d",
             sb.n_checked, sb.req_seen[REQ_ENQ], sb.req_seen[REQ_DEQ],
             sb.req_seen[REQ_PEEK], sb.req_seen[REQ_SEARCH]);
    $display("statuses: ok %0d, full %0d, empty %0d, not found %0d; %0d mismatches",
             sb.status_seen[ST_OK], sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY],
             sb.status_seen[ST_NOTFOUND], sb.n_errors);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("linear_queue_with_search_tb: PASS");
    end else begin
      $display("linear_queue_with_search_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/lqs_pkg.sv
sv/linear_queue_with_search.sv
bench/linear_queue_with_search_tb.sv
